// ===== sv/message_stream_deframer_defines.svh =====
// Assertion macros for the deframer RTL.
`ifndef MESSAGE_STREAM_DEFRAMER_DEFINES_SVH
`define MESSAGE_STREAM_DEFRAMER_DEFINES_SVH

// Plain property checked on every clock edge outside reset.
`define MDF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication checked on every clock edge outside reset.
`define MDF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequent is checked in the following cycle.
`define MDF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/mdf_pkg.sv =====
package mdf_pkg;

  localparam int unsigned HdrBytes = 1 + 4 + 4 + 4 + 8 + 4;
  localparam int unsigned StoreBytes = HdrBytes - 1;
  localparam int unsigned PosW = $clog2(HdrBytes);

  localparam logic KindHeader = 1'b0;
  localparam logic KindPayload = 1'b1;

  typedef struct packed {
    logic        result_kind;
    logic [7:0]  msg_type;
    logic [31:0] sender_id;
    logic [31:0] target_id;
    logic [31:0] message_id;
    logic [63:0] timestamp_us;
    logic [31:0] payload_length;
    logic [7:0]  payload_byte;
    logic        last_of_message;
  } result_t;

endpackage

// ===== sv/mdf_in_stage.sv =====
module mdf_in_stage (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic       adv_i,
  output logic       valid_o,
  output logic [7:0] data_o
);

  logic       valid_q, valid_d;
  logic [7:0] data_q;

  assign in_ready_o = !valid_q || adv_i;
  assign valid_d    = in_ready_o ? in_valid_i : valid_q;
  assign valid_o    = valid_q;
  assign data_o     = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      data_q <= data_byte_i;
    end
  end

endmodule

// ===== sv/mdf_core.sv =====
`include "message_stream_deframer_defines.svh"

module mdf_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fire_i,
  input  logic [7:0]       byte_i,
  output logic             res_valid_o,
  output mdf_pkg::result_t res_o
);

  localparam int unsigned StoreW = 8 * mdf_pkg::StoreBytes;
  localparam logic [mdf_pkg::PosW-1:0] LastPos = mdf_pkg::PosW'(mdf_pkg::StoreBytes);

  logic [mdf_pkg::PosW-1:0] pos_q, pos_d;
  logic                     in_payload_q, in_payload_d;
  logic [31:0]              remaining_q, remaining_d;
  logic [StoreW-1:0]        store_q;
  logic [StoreW+7:0]        full;
  logic [31:0]              rem_dec;
  logic [31:0]              len;

  assign full    = {store_q, byte_i};
  assign len     = full[31:0];
  assign rem_dec = (remaining_q != 32'd0) ? remaining_q - 32'd1 : 32'd0;

  always_comb begin
    pos_d        = pos_q;
    in_payload_d = in_payload_q;
    remaining_d  = remaining_q;
    res_valid_o  = 1'b0;
    res_o        = '0;
    if (in_payload_q) begin
      res_valid_o          = 1'b1;
      res_o.result_kind    = mdf_pkg::KindPayload;
      res_o.payload_byte   = byte_i;
      res_o.last_of_message = (rem_dec == 32'd0);
      remaining_d          = rem_dec;
      if (rem_dec == 32'd0) begin
        in_payload_d = 1'b0;
      end
    end else if (pos_q < LastPos) begin
      pos_d = pos_q + 1'b1;
    end else begin
      res_valid_o           = 1'b1;
      res_o.result_kind     = mdf_pkg::KindHeader;
      res_o.msg_type        = full[199:192];
      res_o.sender_id       = full[191:160];
      res_o.target_id       = full[159:128];
      res_o.message_id      = full[127:96];
      res_o.timestamp_us    = full[95:32];
      res_o.payload_length  = len;
      res_o.last_of_message = (len == 32'd0);
      pos_d                 = '0;
      if (len != 32'd0) begin
        in_payload_d = 1'b1;
        remaining_d  = len;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q        <= '0;
      in_payload_q <= 1'b0;
      remaining_q  <= '0;
    end else if (fire_i) begin
      pos_q        <= pos_d;
      in_payload_q <= in_payload_d;
      remaining_q  <= remaining_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_i && !in_payload_q && (pos_q < LastPos)) begin
      store_q <= {store_q[StoreW-9:0], byte_i};
    end
  end

  `MDF_ASSERT(a_pos_range, pos_q <= LastPos, "header position out of range")
  `MDF_ASSERT_IMP(a_payload_pos, in_payload_q, pos_q == '0, "payload while collecting header")
  `MDF_ASSERT_IMP(a_empty_last, res_valid_o && !res_o.result_kind && (len == 32'd0),
                  res_o.last_of_message, "empty message not marked last")
  `MDF_ASSERT_NEXT(a_payload_end, fire_i && in_payload_q && (remaining_q == 32'd1),
                   !in_payload_q && (pos_q == '0), "payload did not end on last byte")

endmodule

// ===== sv/mdf_out_stage.sv =====
module mdf_out_stage (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  logic             res_valid_i,
  input  mdf_pkg::result_t res_i,
  input  logic             out_ready_i,
  output logic             adv_o,
  output logic             out_valid_o,
  output mdf_pkg::result_t res_o
);

  logic             valid_q, valid_d;
  mdf_pkg::result_t res_q;

  assign adv_o   = !valid_q || out_ready_i;
  assign valid_d = load_i ? res_valid_i : (valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && res_valid_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

// ===== sv/message_stream_deframer.sv =====
// Splits a byte stream into messages, one byte per transaction. Each message starts with
// a 25-byte big-endian header; the 25th header byte yields one header result, and the
// following payload_length bytes each yield a payload result, the final one (or the header
// itself when the length is zero) flagged by last_of_message. Header bytes 1 to 24 give
// no result. A byte can be accepted every cycle; each accepted byte is held in the input
// register, goes through the framing logic, and its result is captured in the result register
// that drives the outputs. While a result waits in the result register, the byte in the input
// register waits too, so the input stalls once both registers are full.
module message_stream_deframer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        result_kind_o,
  output logic [7:0]  msg_type_o,
  output logic [31:0] sender_id_o,
  output logic [31:0] target_id_o,
  output logic [31:0] message_id_o,
  output logic [63:0] timestamp_us_o,
  output logic [31:0] payload_length_o,
  output logic [7:0]  payload_byte_o,
  output logic        last_of_message_o
);

  logic             adv;
  logic             s1_valid;
  logic [7:0]       s1_data;
  logic             fire;
  logic             res_valid;
  mdf_pkg::result_t res;
  mdf_pkg::result_t out_res;

  assign fire = s1_valid && adv;

  mdf_in_stage u_in_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .data_byte_i (data_byte_i),
    .adv_i       (adv),
    .valid_o     (s1_valid),
    .data_o      (s1_data)
  );

  mdf_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .byte_i      (s1_data),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  mdf_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (fire),
    .res_valid_i (res_valid),
    .res_i       (res),
    .out_ready_i (out_ready_i),
    .adv_o       (adv),
    .out_valid_o (out_valid_o),
    .res_o       (out_res)
  );

  assign result_kind_o     = out_res.result_kind;
  assign msg_type_o        = out_res.msg_type;
  assign sender_id_o       = out_res.sender_id;
  assign target_id_o       = out_res.target_id;
  assign message_id_o      = out_res.message_id;
  assign timestamp_us_o    = out_res.timestamp_us;
  assign payload_length_o  = out_res.payload_length;
  assign payload_byte_o    = out_res.payload_byte;
  assign last_of_message_o = out_res.last_of_message;

endmodule

// ===== verif/message_stream_deframer_checker.sv =====
module message_stream_deframer_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [7:0]  data_byte_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic        result_kind_i,
  input  logic [7:0]  msg_type_i,
  input  logic [31:0] sender_id_i,
  input  logic [31:0] target_id_i,
  input  logic [31:0] message_id_i,
  input  logic [63:0] timestamp_us_i,
  input  logic [31:0] payload_length_i,
  input  logic [7:0]  payload_byte_i,
  input  logic        last_of_message_i,
  output int          mismatch_count_o,
  output int          due_count_o
);

  logic [mdf_pkg::PosW-1:0] hdr_pos;
  logic [7:0]               hdr_store [mdf_pkg::StoreBytes];
  logic                     in_body;
  logic [31:0]              body_left;
  mdf_pkg::result_t         due_results [$];
  int                       mismatches;

  function automatic void predict_byte(input logic [7:0] value);
    mdf_pkg::result_t r;
    logic [31:0]      len;
    r = '0;
    if (in_body) begin
      r.result_kind = mdf_pkg::KindPayload;
      r.payload_byte = value;
      if (body_left != 0) begin
        body_left = body_left - 1;
      end
      if (body_left == 0) begin
        r.last_of_message = 1'b1;
        in_body = 1'b0;
      end
      due_results.insert(due_results.size(), r);
    end else if (hdr_pos < mdf_pkg::StoreBytes) begin
      hdr_store[hdr_pos] = value;
      hdr_pos = hdr_pos + 1'b1;
    end else begin
      len = {hdr_store[21], hdr_store[22], hdr_store[23], value};
      r.result_kind = mdf_pkg::KindHeader;
      r.msg_type = hdr_store[0];
      r.sender_id = {hdr_store[1], hdr_store[2], hdr_store[3], hdr_store[4]};
      r.target_id = {hdr_store[5], hdr_store[6], hdr_store[7], hdr_store[8]};
      r.message_id = {hdr_store[9], hdr_store[10], hdr_store[11], hdr_store[12]};
      r.timestamp_us = {hdr_store[13], hdr_store[14], hdr_store[15], hdr_store[16],
                        hdr_store[17], hdr_store[18], hdr_store[19], hdr_store[20]};
      r.payload_length = len;
      r.last_of_message = (len == 0);
      hdr_pos = '0;
      if (len != 0) begin
        in_body = 1'b1;
        body_left = len;
      end
      due_results.insert(due_results.size(), r);
    end
  endfunction

  function automatic bit same_result(input mdf_pkg::result_t a, input mdf_pkg::result_t e);
    return (a.result_kind === e.result_kind) && (a.msg_type === e.msg_type) &&
           (a.sender_id === e.sender_id) && (a.target_id === e.target_id) &&
           (a.message_id === e.message_id) && (a.timestamp_us === e.timestamp_us) &&
           (a.payload_length === e.payload_length) &&
           (a.payload_byte === e.payload_byte) &&
           (a.last_of_message === e.last_of_message);
  endfunction

  function automatic string show(input mdf_pkg::result_t r);
    return $sformatf("kind=%0d type=%h snd=%h tgt=%h mid=%h ts=%h len=%h data=%h last=%0d",
                     r.result_kind, r.msg_type, r.sender_id, r.target_id, r.message_id,
                     r.timestamp_us, r.payload_length, r.payload_byte, r.last_of_message);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    mdf_pkg::result_t seen;
    mdf_pkg::result_t want;
    if (!rst_ni) begin
      hdr_pos = '0;
      in_body = 1'b0;
      body_left = '0;
      due_results.delete();
      mismatches = 0;
      mismatch_count_o <= 0;
      due_count_o <= 0;
    end else begin
      if (in_valid_i && in_ready_i) begin
        predict_byte(data_byte_i);
      end
      if (out_valid_i && out_ready_i) begin
        seen = {result_kind_i, msg_type_i, sender_id_i, target_id_i, message_id_i,
                timestamp_us_i, payload_length_i, payload_byte_i, last_of_message_i};
        if (due_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: result with none expected: %s", $realtime, show(seen));
          end
        end else begin
          want = due_results.pop_front();
          if (!same_result(seen, want)) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: mismatch, expected %s", $realtime, show(want));
              $display("%0t: mismatch, actual   %s", $realtime, show(seen));
            end
          end
        end
      end
      mismatch_count_o <= mismatches;
      due_count_o <= due_results.size();
    end
  end

endmodule

// ===== verif/tb_message_stream_deframer.sv =====
module tb_message_stream_deframer;

  localparam int unsigned RandomBytes = 1600;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned DrainCycles = 20;
  localparam int unsigned MaxGap = 18;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic [7:0]  data_byte = 8'h00;
  logic        out_ready = 1'b0;
  logic        in_ready;
  logic        out_valid;
  logic        result_kind;
  logic [7:0]  msg_type;
  logic [31:0] sender_id;
  logic [31:0] target_id;
  logic [31:0] message_id;
  logic [63:0] timestamp_us;
  logic [31:0] payload_length;
  logic [7:0]  payload_byte;
  logic        last_of_message;

  int          mismatch_count;
  int          due_count;
  int unsigned cycle_count = 0;
  int unsigned bytes_sent = 0;
  bit          tx_calm = 1'b0;
  bit          hold_req = 1'b0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  message_stream_deframer dut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_ready_o        (in_ready),
    .data_byte_i       (data_byte),
    .out_valid_o       (out_valid),
    .out_ready_i       (out_ready),
    .result_kind_o     (result_kind),
    .msg_type_o        (msg_type),
    .sender_id_o       (sender_id),
    .target_id_o       (target_id),
    .message_id_o      (message_id),
    .timestamp_us_o    (timestamp_us),
    .payload_length_o  (payload_length),
    .payload_byte_o    (payload_byte),
    .last_of_message_o (last_of_message)
  );

  message_stream_deframer_checker u_checker (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_ready_i        (in_ready),
    .data_byte_i       (data_byte),
    .out_valid_i       (out_valid),
    .out_ready_i       (out_ready),
    .result_kind_i     (result_kind),
    .msg_type_i        (msg_type),
    .sender_id_i       (sender_id),
    .target_id_i       (target_id),
    .message_id_i      (message_id),
    .timestamp_us_i    (timestamp_us),
    .payload_length_i  (payload_length),
    .payload_byte_i    (payload_byte),
    .last_of_message_i (last_of_message),
    .mismatch_count_o  (mismatch_count),
    .due_count_o       (due_count)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("[message_stream_deframer] ERROR");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] value);
    int unsigned gap;
    gap = tx_calm ? 0 : $urandom_range(0, MaxGap);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= value;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
  endtask

  task automatic send_header(input logic [7:0] kind_byte, input logic [31:0] src,
                             input logic [31:0] dst, input logic [31:0] id,
                             input logic [63:0] stamp, input logic [31:0] len);
    logic [mdf_pkg::HdrBytes*8-1:0] hdr;
    hdr = {kind_byte, src, dst, id, stamp, len};
    for (int i = 0; i < mdf_pkg::HdrBytes; i++) begin
      send_byte(hdr[(mdf_pkg::HdrBytes-i)*8-1 -: 8]);
    end
  endtask

  task automatic send_random_payload(input int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  // Most messages carry short payloads; a few cross the 256-byte boundary.
  task automatic send_random_message();
    int unsigned pick;
    int unsigned len;
    pick = $urandom_range(0, 29);
    if (pick < 4) begin
      len = 0;
    end else if (pick == 4) begin
      len = 1;
    end else if (pick == 5) begin
      len = $urandom_range(256, 300);
    end else if (pick < 9) begin
      len = $urandom_range(0, 255);
    end else begin
      len = $urandom_range(2, 24);
    end
    send_header(8'($urandom_range(0, 255)), pick_word(), pick_word(), pick_word(),
                {pick_word(), pick_word()}, len);
    send_random_payload(len);
  endtask

  initial begin
    int unsigned stall;
    bit          rx_calm;
    rx_calm = 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
      end
      if ($urandom_range(0, 39) == 0) begin
        rx_calm = !rx_calm;
      end
      stall = rx_calm ? 0 : $urandom_range(0, MaxGap);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_header(8'h00, '0, '0, '0, '0, 32'd0);
    tx_calm = 1'b1;
    send_header(8'hFF, '1, '1, '1, '1, 32'd0);
    tx_calm = 1'b0;
    send_header(8'hA5, 32'h8000_0001, 32'h0123_4567, 32'hFEDC_BA98,
                64'h0123_4567_89AB_CDEF, 32'd2);
    send_byte(8'hFF);
    send_byte(8'h00);

    // The receiver holds off while this message streams in back to back.
    hold_req = 1'b1;
    tx_calm = 1'b1;
    send_header(8'h3C, pick_word(), pick_word(), pick_word(), {pick_word(), pick_word()},
                32'd48);
    send_random_payload(48);

    while (bytes_sent < RandomBytes) begin
      tx_calm = ($urandom_range(0, 4) == 0);
      send_random_message();
    end
    in_valid <= 1'b0;
    @(posedge clk);

    while (due_count != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (mismatch_count == 0 && due_count == 0) begin
      $display("[message_stream_deframer] OK");
    end else begin
      $display("[message_stream_deframer] ERROR");
    end
    $finish;
  end

endmodule
